// ----- rtl/core/bdpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpc_pkg
// Shared types, codes and constants for the button debounce press classifier.
// ----------------------------------------------------------------------------
package bdpc_pkg;

    // field and register widths
    localparam int DEBOUNCE_W  = 10;
    localparam int LONG_W      = 16;
    localparam int STABLE_W    = 10;
    localparam int HELD_W      = 17;
    localparam int EVENT_W     = 2;
    localparam int MODE_W      = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // default poll interval in ms
    localparam int POLL_MS_DEFAULT = 10;

    // register reset values and limits
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(50);
    localparam logic [LONG_W-1:0]     LONG_RESET     = LONG_W'(2000);
    localparam logic [LONG_W-1:0]     LONG_MIN_MS    = LONG_W'(100);
    localparam logic [STABLE_W-1:0]   STABLE_MAX     = '1;
    localparam logic [HELD_W-1:0]     HELD_MAX       = '1;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_DEBOUNCE = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_LONG     = CFG_INDEX_W'(1);

    // event codes
    localparam logic [EVENT_W-1:0] EVT_NONE  = EVENT_W'(0);
    localparam logic [EVENT_W-1:0] EVT_SHORT = EVENT_W'(1);
    localparam logic [EVENT_W-1:0] EVT_LONG  = EVENT_W'(2);

    // mode codes as seen on the result channel
    localparam logic [MODE_W-1:0] MODE_CODE_IDLE     = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_CODE_DEBOUNCE = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_CODE_PRESSED  = MODE_W'(2);
    localparam logic [MODE_W-1:0] MODE_CODE_LONG     = MODE_W'(3);

    // press state machine, one-hot
    typedef enum logic [3:0] {
        MODE_IDLE     = 4'b0001,
        MODE_DEBOUNCE = 4'b0010,
        MODE_PRESSED  = 4'b0100,
        MODE_LONG     = 4'b1000
    } mode_t;

    // live configuration
    typedef struct packed {
        logic [DEBOUNCE_W-1:0] settle_ms;
        logic [LONG_W-1:0]     long_press_ms;
    } cfg_t;

    // one result item
    typedef struct packed {
        logic [EVENT_W-1:0] press_event;
        logic [MODE_W-1:0]  mode_now;
        logic               is_held;
    } result_t;

    // one-hot state to output mode code
    function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
        logic [MODE_W-1:0] code;
        unique case (m)
            MODE_IDLE:     code = MODE_CODE_IDLE;
            MODE_DEBOUNCE: code = MODE_CODE_DEBOUNCE;
            MODE_PRESSED:  code = MODE_CODE_PRESSED;
            MODE_LONG:     code = MODE_CODE_LONG;
            default:       code = MODE_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

// ----- rtl/core/bdpc_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpc_cfg_regs
// Configuration registers: debounce time and long-press threshold.
// ----------------------------------------------------------------------------
module bdpc_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bdpc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bdpc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output bdpc_pkg::cfg_t                    cfg
);
    import bdpc_pkg::*;

    logic [DEBOUNCE_W-1:0] debounce_reg;
    logic [DEBOUNCE_W-1:0] debounce_next;
    logic [LONG_W-1:0]     long_reg;
    logic [LONG_W-1:0]     long_next;

    // writes are always taken
    assign cfg_ready = 1'b1;

    // register decode; short thresholds and unknown indexes are dropped
    always_comb begin
        debounce_next = debounce_reg;
        long_next     = long_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_IDX_DEBOUNCE: debounce_next = cfg_data[DEBOUNCE_W-1:0];
                CFG_IDX_LONG: begin
                    if (cfg_data[LONG_W-1:0] >= LONG_MIN_MS) begin
                        long_next = cfg_data[LONG_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RESET;
            long_reg     <= LONG_RESET;
        end else begin
            debounce_reg <= debounce_next;
            long_reg     <= long_next;
        end
    end

    assign cfg.settle_ms     = debounce_reg;
    assign cfg.long_press_ms = long_reg;

endmodule

// ----- rtl/core/bdpc_press_fsm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpc_press_fsm
// Debounce and press classification state machine, one sample per step.
// ----------------------------------------------------------------------------
module bdpc_press_fsm #(
    parameter int POLL_MS = bdpc_pkg::POLL_MS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  logic               pin_level,
    input  logic               read_error,
    input  bdpc_pkg::cfg_t     cfg,
    output bdpc_pkg::result_t  result
);
    import bdpc_pkg::*;

    localparam int POLL_W = $clog2(POLL_MS + 1);
    localparam int PROD_W = STABLE_W + 1 + POLL_W;

    mode_t               mode_reg;
    mode_t               mode_next;
    logic [STABLE_W-1:0] stable_reg;
    logic [STABLE_W-1:0] stable_next;
    logic [HELD_W-1:0]   held_reg;
    logic [HELD_W-1:0]   held_next;
    logic                fired_reg;
    logic                fired_next;

    logic                pressed;
    logic [STABLE_W-1:0] stable_inc;
    logic [STABLE_W:0]   stable_plus;
    logic [PROD_W-1:0]   span_ms;
    logic                confirm;
    logic [HELD_W:0]     held_sum;
    logic [HELD_W-1:0]   held_sat;
    logic [EVENT_W-1:0]  evt;

    assign pressed = ~pin_level;

    // debounce count with saturation; confirmed once
    // debounce time < (count + 1) * POLL_MS, i.e. count >= debounce time / POLL_MS
    assign stable_inc  = (stable_reg < STABLE_MAX) ? stable_reg + STABLE_W'(1) : stable_reg;
    assign stable_plus = {1'b0, stable_inc} + (STABLE_W + 1)'(1);
    assign span_ms     = PROD_W'(stable_plus) * PROD_W'(POLL_MS);
    assign confirm     = PROD_W'(cfg.settle_ms) < span_ms;

    // held time with saturation
    assign held_sum = {1'b0, held_reg} + (HELD_W + 1)'(POLL_MS);
    assign held_sat = held_sum[HELD_W] ? HELD_MAX : held_sum[HELD_W-1:0];

    // next state and event
    always_comb begin
        mode_next   = mode_reg;
        stable_next = stable_reg;
        held_next   = held_reg;
        fired_next  = fired_reg;
        evt         = EVT_NONE;
        if (!read_error) begin
            unique case (mode_reg)
                MODE_IDLE: begin
                    if (pressed) begin
                        mode_next   = MODE_DEBOUNCE;
                        stable_next = '0;
                        fired_next  = 1'b0;
                    end
                end
                MODE_DEBOUNCE: begin
                    if (pressed) begin
                        stable_next = stable_inc;
                        if (confirm) begin
                            mode_next = MODE_PRESSED;
                            held_next = '0;
                        end
                    end else begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_PRESSED: begin
                    if (!pressed) begin
                        if (!fired_reg) begin
                            evt = EVT_SHORT;
                        end
                        mode_next = MODE_IDLE;
                    end else begin
                        held_next = held_sat;
                        if ((held_sat >= HELD_W'(cfg.long_press_ms)) && !fired_reg) begin
                            fired_next = 1'b1;
                            evt        = EVT_LONG;
                            mode_next  = MODE_LONG;
                        end
                    end
                end
                MODE_LONG: begin
                    if (!pressed) begin
                        mode_next = MODE_IDLE;
                    end
                end
                default: mode_next = MODE_IDLE;
            endcase
        end
    end

    // state registers advance once per processed sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            stable_reg <= '0;
            held_reg   <= '0;
            fired_reg  <= 1'b0;
        end else if (step) begin
            mode_reg   <= mode_next;
            stable_reg <= stable_next;
            held_reg   <= held_next;
            fired_reg  <= fired_next;
        end
    end

    assign result.press_event = evt;
    assign result.mode_now    = mode_code(mode_next);
    assign result.is_held     = (mode_next == MODE_PRESSED) || (mode_next == MODE_LONG);

endmodule

// ----- rtl/core/button_debounce_press_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_press_classifier
// Debounces polled active-low button samples and reports short and long presses.
// ----------------------------------------------------------------------------
// Each accepted sample yields exactly one result (event, mode, held flag). A
// sample is taken every cycle while s_ready is high; its result passes through
// the input register and then the result register, with the press state
// machine in between. A stalled result stops the input only once both
// registers are full. Configuration writes are always ready and take effect on
// the next sample; the debounce time resets to 50 ms and long_press_ms to 2000,
// and a long_press_ms write below 100 is dropped.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier #(
    parameter int POLL_MS = bdpc_pkg::POLL_MS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // sample channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_pin_level,
    input  logic                              s_read_error,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [bdpc_pkg::EVENT_W-1:0]      m_press_event,
    output logic [bdpc_pkg::MODE_W-1:0]       m_mode_now,
    output logic                              m_is_held,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bdpc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bdpc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bdpc_pkg::*;

    cfg_t    cfg;
    result_t result;
    result_t out_reg;

    logic in_valid_reg;
    logic in_valid_next;
    logic pin_reg;
    logic err_reg;
    logic out_valid_reg;
    logic out_valid_next;
    logic advance;
    logic s_xfer;

    // configuration registers
    bdpc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // handshake control
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_xfer  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input sample register
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            pin_reg <= s_pin_level;
            err_reg <= s_read_error;
        end
    end

    // press state machine
    bdpc_press_fsm #(
        .POLL_MS (POLL_MS)
    ) u_fsm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .pin_level  (pin_reg),
        .read_error (err_reg),
        .cfg        (cfg),
        .result     (result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_press_event = out_reg.press_event;
    assign m_mode_now    = out_reg.mode_now;
    assign m_is_held     = out_reg.is_held;

endmodule
